// ----- sv/pulse_width_tachometer_unit_assert.svh -----
// Assertion macros for the pulse width tachometer unit.
// Used by the RTL file that carries concurrent checks (pwt_queue); expects clk and rst_n in scope.
`ifndef PULSE_WIDTH_TACHOMETER_UNIT_ASSERT_SVH
`define PULSE_WIDTH_TACHOMETER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check outside reset.
`define PWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every edge, reset included.
`define PWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWT_ASSERT(lbl, prop, msg)
`define PWT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/pwt_pkg.sv -----
// Shared types, widths, register codes and helper functions for the tachometer.
// No dependencies; the modules and the output and configuration interfaces import it.
package pwt_pkg;

  localparam int CNT_W   = 28;   // width of the tick counter
  localparam int TICKS_W = 28;
  localparam int TOUT_W  = 28;
  localparam int SCALE_W = 32;
  localparam int SPEED_W = 16;
  localparam int RANGE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int WIDE_W  = (CNT_W > TICKS_W) ? CNT_W : TICKS_W;
  localparam int REM_W   = CNT_W + 1;
  localparam int STEP_W  = $clog2(SCALE_W);
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(SCALE_W - 1);

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(7500000);
  localparam logic [TOUT_W-1:0]  TOUT_RST  = TOUT_W'(25000000);
  localparam logic [SPEED_W-1:0] LOW_RST   = SPEED_W'(200);
  localparam logic [SPEED_W-1:0] HIGH_RST  = SPEED_W'(9000);

  localparam logic [RANGE_W-1:0] RANGE_INSIDE = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_BELOW  = 2'd1;
  localparam logic [RANGE_W-1:0] RANGE_ABOVE  = 2'd2;

  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_LOW     = 2'd2,
    REG_HIGH    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_HOLD = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [TOUT_W-1:0]  tout;
    logic [SPEED_W-1:0] low;
    logic [SPEED_W-1:0] high;
  } cfg_t;

  typedef struct packed {
    count_t count;
    logic   timed_out;
  } meas_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic over_timeout(count_t c, logic [TOUT_W-1:0] t);
    logic [WIDE_W-1:0] cw;
    logic [WIDE_W-1:0] tw;
    cw = WIDE_W'(c);
    tw = WIDE_W'(t);
    return cw > tw;
  endfunction

  function automatic logic [TICKS_W-1:0] sat_ticks(count_t c);
    logic [WIDE_W-1:0] cw;
    cw = WIDE_W'(c);
    if (cw > WIDE_W'(TICKS_MAX)) begin
      return TICKS_MAX;
    end
    return TICKS_W'(cw);
  endfunction

endpackage

// ----- sv/pwt_in_if.sv -----
// Tick input channel: valid/ready handshake with level and arm.
// No dependencies.
interface pwt_in_if;
  logic valid;
  logic ready;
  logic level;
  logic arm;

  modport source (output valid, output level, output arm, input ready);
  modport sink (input valid, input level, input arm, output ready);
endinterface

// ----- sv/pwt_out_if.sv -----
// Result channel: valid/ready handshake with count, timeout flag, speed and range code.
// Depends on pwt_pkg for field widths.
interface pwt_out_if import pwt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] pulse_ticks;
  logic               timed_out;
  logic [SPEED_W-1:0] speed_tenths;
  logic [RANGE_W-1:0] range_code;

  modport source (output valid, output pulse_ticks, output timed_out,
                  output speed_tenths, output range_code, input ready);
  modport sink (input valid, input pulse_ticks, input timed_out,
                input speed_tenths, input range_code, output ready);
endinterface

// ----- sv/pwt_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and write data.
// Depends on pwt_pkg for widths.
interface pwt_cfg_if import pwt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCALE_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/pwt_front.sv -----
// Front end: per-tick edge detection, phase control and pulse counting.
// Depends on pwt_pkg; pushes finished measurements into the queue.
module pwt_front import pwt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   acc,
  input  logic   level,
  input  logic   arm,
  output logic   push,
  output meas_t  meas
);

  phase_t phase_r, phase_nxt;
  logic   prev_r;
  count_t cnt_r, cnt_nxt;
  logic   emit;
  logic   tout;
  count_t emit_cnt;
  logic   rise;
  count_t cnt_inc;
  logic   at_top;

  assign rise    = level && !prev_r;
  assign cnt_inc = cnt_r + 1'b1;
  assign at_top  = &cnt_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rise) begin
            phase_nxt = emit ? PH_IDLE : PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (emit) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = arm ? PH_WAIT : PH_IDLE;
        end
      endcase
    end
  end

  // counter update and measurement end
  always_comb begin
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    tout     = 1'b0;
    emit_cnt = cnt_r;
    unique case (phase_r)
      PH_WAIT: begin
        if (rise) begin
          cnt_nxt  = CNT_W'(1);
          emit_cnt = CNT_W'(1);
          tout     = 1'b1;
          emit     = over_timeout(CNT_W'(1), cfg.tout);
        end
      end
      PH_COUNT: begin
        if (!level) begin
          emit = 1'b1;
        end else begin
          if (!at_top) begin
            cnt_nxt = cnt_inc;
          end
          emit_cnt = at_top ? cnt_r : cnt_inc;
          tout     = 1'b1;
          emit     = at_top || over_timeout(cnt_inc, cfg.tout);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  assign push = acc && emit;
  assign meas = '{count: emit_cnt, timed_out: tout};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prev_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (acc) begin
        prev_r <= level;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

// ----- sv/pwt_queue.sv -----
// Short measurement queue between the counting front end and the divider back end.
// Depends on pwt_pkg and the assertion macro header.
`include "pulse_width_tachometer_unit_assert.svh"
module pwt_queue import pwt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  meas_t     din,
  input  logic      pop,
  output meas_t     dout,
  output q_status_t status
);

  meas_t             entries_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign dout         = entries_r[rd_ptr_r];
  assign status.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `PWT_ASSERT(a_no_push_full, push |-> !status.full, "measurement pushed into a full queue")
  `PWT_ASSERT(a_no_pop_empty, pop |-> !status.empty, "pop from an empty queue")
  `PWT_ASSERT(a_cnt_range, cnt_r <= QCNT_W'(Q_DEPTH), "queue fill count out of range")
  `PWT_ASSERT(a_cnt_track, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1),
              "queue fill count did not advance on push")

endmodule

// ----- sv/pwt_back.sv -----
// Back end: bit-serial divider for the speed, saturation, range code and result register.
// Depends on pwt_pkg and the pwt_out_if interface.
module pwt_back import pwt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  q_status_t       q_status,
  input  meas_t           q_head,
  output logic            pop,
  pwt_out_if.source       out_ch
);

  back_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [REM_W-1:0]   rem_r;
  logic [SCALE_W-1:0] quo_r;
  count_t             div_r;
  logic               tout_r;
  logic               out_free;
  logic               load_out;
  logic [REM_W-1:0]   rem_sh;
  logic               ge;
  logic [REM_W-1:0]   rem_step;
  logic [SCALE_W-1:0] quo_step;
  logic [SPEED_W-1:0] speed;
  logic [RANGE_W-1:0] range;

  logic               out_valid_r;
  logic [TICKS_W-1:0] ticks_out_r;
  logic               tout_out_r;
  logic [SPEED_W-1:0] speed_out_r;
  logic [RANGE_W-1:0] range_out_r;

  assign out_free = !out_valid_r || out_ch.ready;

  // one quotient bit a cycle, restoring
  assign rem_sh   = {rem_r[REM_W-2:0], quo_r[SCALE_W-1]};
  assign ge       = rem_sh >= REM_W'(div_r);
  assign rem_step = ge ? (rem_sh - REM_W'(div_r)) : rem_sh;
  assign quo_step = {quo_r[SCALE_W-2:0], ge};

  assign speed = (|quo_r[SCALE_W-1:SPEED_W]) ? SPEED_MAX : quo_r[SPEED_W-1:0];

  always_comb begin
    if (speed < cfg.low) begin
      range = RANGE_BELOW;
    end else if (speed > cfg.high) begin
      range = RANGE_ABOVE;
    end else begin
      range = RANGE_INSIDE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == STEP_LAST) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      BK_IDLE: pop      = !q_status.empty;
      BK_HOLD: load_out = out_free;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem_r  <= '0;
      quo_r  <= cfg.scale;
      div_r  <= q_head.count;
      tout_r <= q_head.timed_out;
      step_r <= '0;
    end else if (state_r == BK_DIV) begin
      rem_r  <= rem_step;
      quo_r  <= quo_step;
      step_r <= step_r + 1'b1;
    end
    if (load_out) begin
      ticks_out_r <= sat_ticks(div_r);
      tout_out_r  <= tout_r;
      speed_out_r <= speed;
      range_out_r <= range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pulse_ticks  = ticks_out_r;
  assign out_ch.timed_out    = tout_out_r;
  assign out_ch.speed_tenths = speed_out_r;
  assign out_ch.range_code   = range_out_r;

endmodule

// ----- sv/pulse_width_tachometer_unit.sv -----
// Pulse width tachometer: one sampled encoder level and arm request enter per clock, one
// transaction per cycle, while the two-entry measurement queue has room. After an arm the
// unit counts ticks from the next rising edge to the falling edge, or stops at the timeout,
// and reports the count, a timeout flag, the speed (scale / count in tenths of RPM,
// saturated at 65535) and a range code. The back end pops a measurement, runs the
// bit-serial divider, then saturates, classifies and loads the result before popping again.
// The input stalls only when the queue is full; a measurement covers at least an arm and a rise tick.
module pulse_width_tachometer_unit import pwt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pwt_in_if.sink    in_ch,
  pwt_out_if.source out_ch,
  pwt_cfg_if.sink   cfg_ch
);

  cfg_t      cfg_r;
  logic      acc;
  logic      push;
  logic      pop;
  meas_t     meas;
  meas_t     q_head;
  q_status_t q_status;
  cfg_reg_t  reg_sel;

  assign cfg_ch.ready = 1'b1;
  assign reg_sel      = cfg_reg_t'(cfg_ch.index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale <= SCALE_RST;
      cfg_r.tout  <= TOUT_RST;
      cfg_r.low   <= LOW_RST;
      cfg_r.high  <= HIGH_RST;
    end else if (cfg_ch.valid) begin
      unique case (reg_sel)
        REG_SCALE:   cfg_r.scale <= cfg_ch.data;
        REG_TIMEOUT: cfg_r.tout  <= cfg_ch.data[TOUT_W-1:0];
        REG_LOW:     cfg_r.low   <= cfg_ch.data[SPEED_W-1:0];
        REG_HIGH:    cfg_r.high  <= cfg_ch.data[SPEED_W-1:0];
        default:     cfg_r       <= cfg_r;
      endcase
    end
  end

  // hold the tick stream while the queue has no room for a possible result
  assign in_ch.ready = !q_status.full;
  assign acc         = in_ch.valid && in_ch.ready;

  pwt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .acc   (acc),
    .level (in_ch.level),
    .arm   (in_ch.arm),
    .push  (push),
    .meas  (meas)
  );

  pwt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .din    (meas),
    .pop    (pop),
    .dout   (q_head),
    .status (q_status)
  );

  pwt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_status (q_status),
    .q_head   (q_head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
